### src/blg_pkg.sv
// Shared types and constants for the battery level grader.
`timescale 1ns / 1ps
package blg_pkg;

    localparam int ADC_W     = 12;
    localparam int GRADE_W   = 3;
    localparam int OP_W      = 2;
    localparam int NUM_REGS  = 7;
    localparam int CFG_IDX_W = 3;

    typedef logic [ADC_W-1:0]     t_adc;
    typedef logic [GRADE_W-1:0]   t_grade;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // request opcodes
    localparam t_op OP_SAMPLE = 2'd0;
    localparam t_op OP_CLEAR  = 2'd1;
    localparam t_op OP_FULL   = 2'd2;
    localparam t_op OP_NONE   = 2'd3;

    // threshold register indexes
    localparam t_cfg_idx REG_IGNORE   = 3'd0;
    localparam t_cfg_idx REG_CRITICAL = 3'd1;
    localparam t_cfg_idx REG_GRADE0   = 3'd2;
    localparam t_cfg_idx REG_GRADE1   = 3'd3;
    localparam t_cfg_idx REG_GRADE2   = 3'd4;
    localparam t_cfg_idx REG_GRADE3   = 3'd5;
    localparam t_cfg_idx REG_CHG_HOLD = 3'd6;

    localparam t_adc REG_RESET [NUM_REGS] = '{
        12'd2134, 12'd3090, 12'd3115, 12'd3158, 12'd3243, 12'd3397, 12'd3422
    };

    localparam t_grade GRADE_0    = 3'd0;
    localparam t_grade GRADE_1    = 3'd1;
    localparam t_grade GRADE_2    = 3'd2;
    localparam t_grade GRADE_3    = 3'd3;
    localparam t_grade GRADE_FULL = 3'd4;
    localparam t_grade GRADE_CRIT = 3'd5;

    localparam t_adc       ONE_VOLT_COUNT = 12'd854;
    localparam logic [1:0] CONFIRM_NEEDED = 2'd3;
    localparam logic [7:0] SHUT_COUNT     = 8'd3;

endpackage

### src/blg_if.sv
// Request, result and register write channels of the battery level grader.
`timescale 1ns / 1ps
interface blg_req_if;
    import blg_pkg::*;
    logic valid;
    logic ready;
    t_op  op;
    t_adc sample;
    logic charging_pin;
    logic charge_status_pin;

    modport source (output valid, op, sample, charging_pin, charge_status_pin, input ready);
    modport sink   (input valid, op, sample, charging_pin, charge_status_pin, output ready);
endinterface

interface blg_res_if;
    import blg_pkg::*;
    logic   valid;
    logic   ready;
    t_grade grade;
    t_adc   average_value;
    logic   is_low;
    logic   low_to_shut;
    logic   is_charging;

    modport source (output valid, grade, average_value, is_low, low_to_shut, is_charging,
                    input ready);
    modport sink   (input valid, grade, average_value, is_low, low_to_shut, is_charging,
                    output ready);
endinterface

interface blg_cfg_if;
    import blg_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_adc     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/battery_level_grader.sv
// Top level of the battery level grader: window averaging, grading and hysteresis.
`timescale 1ns / 1ps
// One request is taken per clock whenever the result register is free or being
// drained. A sample request adds into the running window; the request that
// closes a window of SAMPLES samples, and every clear or full-check request,
// yields one result, registered in turn through the window add, the reciprocal
// multiply for the average and the grading. Sample requests that do not close a
// window and opcode 3 yield no result. Throughput is one request per cycle;
// it is bounded by the window accumulator and the grade/hysteresis update, both
// of which feed back on their own registers. The whole pipeline stalls as one
// while a result waits on o_res.ready. Threshold registers take a write every
// cycle and are meant to be changed only while no request is in flight; writes
// to index 7 are dropped.
module battery_level_grader #(
    parameter int SAMPLES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    blg_req_if.sink   i_req,
    blg_cfg_if.sink   i_cfg,
    blg_res_if.source o_res
);
    import blg_pkg::*;

    localparam int CNT_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int SUM_W = ADC_W + $clog2(SAMPLES);
    localparam int SHIFT = SUM_W + $clog2(SAMPLES);
    localparam int M_W   = SUM_W + 1;
    localparam int P_W   = SUM_W + M_W;
    // ceil(2^SHIFT / SAMPLES): exact floor division for any SUM_W-bit sum
    localparam logic [M_W-1:0] RECIP = M_W'(((64'd1 << SHIFT) + SAMPLES - 1) / SAMPLES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

    // ---------------- threshold registers ----------------
    t_adc r_thr [NUM_REGS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= REG_RESET;
        end else if (i_cfg.valid && (i_cfg.index < t_cfg_idx'(NUM_REGS))) begin
            r_thr[i_cfg.index] <= i_cfg.data;
        end
    end

    // ---------------- pipeline advance ----------------
    logic r_out_valid;
    logic w_en;
    logic w_take;
    assign w_en        = !r_out_valid || o_res.ready;
    assign i_req.ready = w_en;
    assign w_take      = i_req.valid && w_en;

    // ---------------- stage 1: window accumulate ----------------
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_count;
    logic [SUM_W-1:0] w_sum_add;
    logic             w_win_done;
    logic             w_s1_valid;

    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [SUM_W-1:0] r_s1_sum;
    logic             r_s1_chg;
    logic             r_s1_full;

    logic w_in_chg;
    logic w_in_full;

    assign w_sum_add  = r_sum + SUM_W'(i_req.sample);
    assign w_win_done = (r_count == CNT_LAST);
    assign w_in_chg   = !i_req.charging_pin && !i_req.charge_status_pin;
    assign w_in_full  = !i_req.charging_pin && i_req.charge_status_pin;
    // a result is due for a window close and for every clear or full check
    assign w_s1_valid = w_take && (((i_req.op == OP_SAMPLE) && w_win_done)
                                   || (i_req.op inside {OP_CLEAR, OP_FULL}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_s1_valid;
            if (w_take && (i_req.op == OP_SAMPLE)) begin
                if (w_win_done) begin
                    r_sum   <= '0;
                    r_count <= '0;
                end else begin
                    r_sum   <= w_sum_add;
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op   <= i_req.op;
            r_s1_sum  <= w_sum_add;
            r_s1_chg  <= w_in_chg;
            r_s1_full <= w_in_full;
        end
    end

    // ---------------- stage 2: average by reciprocal multiply ----------------
    logic [P_W-1:0] w_prod;
    logic           r_s2_valid;
    t_op            r_s2_op;
    t_adc           r_s2_avg;
    logic           r_s2_chg;
    logic           r_s2_full;

    assign w_prod = {{M_W{1'b0}}, r_s1_sum} * {{SUM_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_op   <= r_s1_op;
            r_s2_avg  <= w_prod[SHIFT +: ADC_W];
            r_s2_chg  <= r_s1_chg;
            r_s2_full <= r_s1_full;
        end
    end

    // ---------------- stage 3: grading and hysteresis ----------------
    t_adc       r_avg;
    t_grade     r_grade;
    logic [7:0] r_run;
    logic [1:0] r_confirm;
    logic       r_low;
    logic       r_first;

    t_adc       n_avg;
    t_grade     n_grade;
    logic [7:0] n_run;
    logic [1:0] n_confirm;
    logic       n_low;
    logic       n_first;

    t_grade     w_g;
    logic       w_crit;
    logic [1:0] w_inc;

    // threshold ladder, bottom up, strict less-than
    always_comb begin
        w_crit = (r_s2_avg < r_thr[REG_CRITICAL]);
        if (w_crit) begin
            w_g = GRADE_CRIT;
        end else if (r_s2_avg < r_thr[REG_GRADE0]) begin
            w_g = GRADE_0;
        end else if (r_s2_avg < r_thr[REG_GRADE1]) begin
            w_g = GRADE_1;
        end else if (r_s2_avg < r_thr[REG_GRADE2]) begin
            w_g = GRADE_2;
        end else if (r_s2_avg < r_thr[REG_GRADE3]) begin
            w_g = GRADE_3;
        end else if (r_s2_chg && (r_s2_avg < r_thr[REG_CHG_HOLD])) begin
            w_g = GRADE_3;  // charging: hold below near-full
        end else begin
            w_g = GRADE_FULL;
        end
    end

    assign w_inc = r_confirm + 2'd1;

    always_comb begin
        n_avg     = r_avg;
        n_grade   = r_grade;
        n_run     = r_run;
        n_confirm = r_confirm;
        n_low     = r_low;
        n_first   = r_first;
        case (r_s2_op)
            OP_SAMPLE: begin
                n_avg   = r_s2_avg;
                n_first = (r_s2_avg < ONE_VOLT_COUNT);
                // averages under the ignore threshold touch nothing else
                if (!(r_s2_avg < r_thr[REG_IGNORE])) begin
                    if (w_crit) begin
                        n_run = (r_run != 8'hFF) ? r_run + 8'd1 : r_run;
                    end else begin
                        n_run = '0;
                    end
                    if (r_first) begin
                        // recovering from a dead reading: adopt at once
                        n_grade   = w_g;
                        n_confirm = '0;
                    end else begin
                        if (r_grade != w_g) begin
                            if (w_inc == CONFIRM_NEEDED) begin
                                n_confirm = '0;
                                n_grade   = w_g;
                            end else begin
                                n_confirm = w_inc;
                            end
                        end else begin
                            n_confirm = '0;
                        end
                        n_low = (n_grade == GRADE_0) || (n_grade == GRADE_CRIT);
                    end
                    if (r_s2_full) begin
                        n_grade   = GRADE_FULL;
                        n_run     = '0;
                        n_confirm = '0;
                    end
                end
            end
            OP_CLEAR: n_run = '0;
            OP_FULL: begin
                if (r_s2_full) begin
                    n_grade = GRADE_FULL;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg     <= '0;
            r_grade   <= GRADE_0;
            r_run     <= '0;
            r_confirm <= '0;
            r_low     <= 1'b0;
            r_first   <= 1'b1;
        end else if (w_en && r_s2_valid) begin
            r_avg     <= n_avg;
            r_grade   <= n_grade;
            r_run     <= n_run;
            r_confirm <= n_confirm;
            r_low     <= n_low;
            r_first   <= n_first;
        end
    end

    // ---------------- result register ----------------
    t_grade r_out_grade;
    t_adc   r_out_avg;
    logic   r_out_low;
    logic   r_out_shut;
    logic   r_out_chg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s2_valid) begin
            r_out_grade <= n_grade;
            r_out_avg   <= n_avg;
            r_out_low   <= (n_grade == GRADE_CRIT) || ((n_grade == GRADE_0) && n_low);
            r_out_shut  <= (n_grade == GRADE_CRIT) && (n_run >= SHUT_COUNT);
            r_out_chg   <= r_s2_chg;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.grade         = r_out_grade;
    assign o_res.average_value = r_out_avg;
    assign o_res.is_low        = r_out_low;
    assign o_res.low_to_shut   = r_out_shut;
    assign o_res.is_charging   = r_out_chg;

    // ---------------- assertions ----------------
    a_shut_implies_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (!o_res.low_to_shut || o_res.is_low))
        else $error("shutdown flag without low flag");

    a_grade_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.grade <= GRADE_CRIT))
        else $error("grade out of range");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_LAST)
        else $error("window count past window length");

    a_none_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.op == OP_NONE)) |=> !r_s1_valid)
        else $error("undefined opcode entered the pipeline");

endmodule

### test/tb.sv
// Self-checking testbench for the battery level grader: random requests against a grade predictor.
`timescale 1ns / 1ps
module tb;
    import blg_pkg::*;

    localparam int SAMPLES       = 8;
    localparam int SETTLE_CYCLES = 8;       // drains the result pipeline, with margin
    localparam int CYCLE_LIMIT   = 500000;
    localparam int IDLE_MAX      = 18;

    // Charger pin pairs, written {charging_pin, charge_status_pin}.
    localparam logic [1:0] PINS_CHARGING   = 2'b00;
    localparam logic [1:0] PINS_FULL       = 2'b01;
    localparam logic [1:0] PINS_NO_CHARGER = 2'b10;

    // Index past the last threshold; the block drops writes to it.
    localparam t_cfg_idx REG_SPARE = 3'd7;

    typedef struct packed {
        t_op        op;
        t_adc       sample;
        logic [1:0] pins;
    } t_request;

    typedef struct packed {
        t_grade grade;
        t_adc   average;
        logic   is_low;
        logic   low_to_shut;
        logic   is_charging;
    } t_status;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    blg_req_if req_if ();
    blg_res_if res_if ();
    blg_cfg_if cfg_if ();

    battery_level_grader #(
        .SAMPLES(SAMPLES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Grade predictor state: its own copy of the thresholds and of every
    // register the block keeps between requests.
    // ------------------------------------------------------------------
    t_adc            thresh [NUM_REGS];
    logic [ADC_W+6:0] win_sum;        // room for 64 full-scale samples
    int              win_cnt;
    t_adc            last_avg;
    t_grade          cur_grade;
    logic [7:0]      crit_run;        // consecutive critical windows, sticks at 255
    logic [1:0]      confirm_cnt;     // differing grades seen in a row
    logic            low_flag;        // grade was 0 or critical after the last confirmed check
    logic            below_volt;      // previous average stood under one volt

    t_request req_backlog_q [$];      // requests not yet offered to the block
    t_status  status_due_q [$];       // predicted status reports, oldest first

    t_request taken;
    t_request nxt_req;
    t_status  due;
    t_status  got;
    t_status  want;
    bit       req_taken;
    bit       quiet;                  // no idling on either side
    int       idle_odds;              // one idle burst per idle_odds handshakes, on average
    int       req_gap;
    int       ready_gap;
    int       mismatches;
    int       requests_taken;
    int       statuses_checked;
    int       windows_closed;
    int       cfg_writes;
    int       cycle_count;

    // Grade one finished window average. Mirrors the hysteresis, the
    // first-window shortcut and the full-charge override.
    function automatic void grade_window(input t_adc avg, input bit charging, input bit full);
        t_grade g;
        bit     was_first;
        was_first  = below_volt;
        below_volt = (avg < ONE_VOLT_COUNT);
        // an ignored average is stored but leaves grade, counts and marks alone
        if (avg < thresh[REG_IGNORE])
            return;
        if (avg < thresh[REG_CRITICAL]) begin
            g = GRADE_CRIT;
            if (crit_run != 8'hFF)
                crit_run++;
        end else begin
            // ladder walked bottom up with strict less-than; no ordering assumed
            if (avg < thresh[REG_GRADE0])
                g = GRADE_0;
            else if (avg < thresh[REG_GRADE1])
                g = GRADE_1;
            else if (avg < thresh[REG_GRADE2])
                g = GRADE_2;
            else if (avg < thresh[REG_GRADE3])
                g = GRADE_3;
            else if (charging && avg < thresh[REG_CHG_HOLD])
                g = GRADE_3;
            else
                g = GRADE_FULL;
            crit_run = '0;
        end
        if (was_first) begin
            // first window after a sub-1V average: grade taken at once
            cur_grade   = g;
            confirm_cnt = '0;
        end else begin
            if (cur_grade != g) begin
                if (confirm_cnt == CONFIRM_NEEDED - 1) begin
                    confirm_cnt = '0;
                    cur_grade   = g;
                end else begin
                    confirm_cnt++;
                end
            end else begin
                confirm_cnt = '0;
            end
            low_flag = (cur_grade == GRADE_0 || cur_grade == GRADE_CRIT);
        end
        if (full) begin
            cur_grade   = GRADE_FULL;
            crit_run    = '0;
            confirm_cnt = '0;
        end
    endfunction

    // Apply one accepted request; returns 1 when it yields a status report.
    function automatic bit apply_request(input t_request r, output t_status s);
        bit charging;
        bit full;
        charging = (r.pins == PINS_CHARGING);
        full     = (r.pins == PINS_FULL);
        case (r.op)
            OP_SAMPLE: begin
                win_sum = win_sum + (ADC_W + 7)'(r.sample);
                win_cnt++;
                if (win_cnt < SAMPLES)
                    return 1'b0;
                last_avg = t_adc'(win_sum / SAMPLES);
                win_sum  = '0;
                win_cnt  = 0;
                windows_closed++;
                grade_window(last_avg, charging, full);
            end
            OP_CLEAR: crit_run = '0;
            OP_FULL: begin
                if (full)
                    cur_grade = GRADE_FULL;
            end
            default: return 1'b0;
        endcase
        s.grade       = cur_grade;
        s.average     = last_avg;
        s.is_low      = (cur_grade == GRADE_CRIT) || (cur_grade == GRADE_0 && low_flag);
        s.low_to_shut = (cur_grade == GRADE_CRIT) && (crit_run >= SHUT_COUNT);
        s.is_charging = charging;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [ADC_W-1:0] seen,
                               input logic [ADC_W-1:0] wanted);
        if (seen !== wanted)
            report_mismatch($sformatf("status #%0d %s: got %0d, expected %0d",
                                      statuses_checked, name, seen, wanted));
    endtask

    // ------------------------------------------------------------------
    // Rising edge: every handshake is observed here, before the block's
    // own registers move, so the sampled values are the pre-edge ones.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thresh      = REG_RESET;
            win_sum     = '0;
            win_cnt     = 0;
            last_avg    = '0;
            cur_grade   = GRADE_0;
            crit_run    = '0;
            confirm_cnt = '0;
            low_flag    = 1'b0;
            below_volt  = 1'b1;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index < NUM_REGS)
                    thresh[cfg_if.index] = cfg_if.data;
                cfg_writes++;
            end
            if (req_if.valid && req_if.ready) begin
                taken.op     = req_if.op;
                taken.sample = req_if.sample;
                taken.pins   = {req_if.charging_pin, req_if.charge_status_pin};
                if (apply_request(taken, due))
                    status_due_q.push_back(due);
                req_taken = 1'b1;
                requests_taken++;
            end
            if (res_if.valid && res_if.ready) begin
                got.grade       = res_if.grade;
                got.average     = res_if.average_value;
                got.is_low      = res_if.is_low;
                got.low_to_shut = res_if.low_to_shut;
                got.is_charging = res_if.is_charging;
                if (status_due_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected status: grade %0d average %0d",
                                              got.grade, got.average));
                end else begin
                    want = status_due_q.pop_front();
                    check_field("grade", got.grade, want.grade);
                    check_field("average_value", got.average, want.average);
                    check_field("is_low", got.is_low, want.is_low);
                    check_field("low_to_shut", got.low_to_shut, want.low_to_shut);
                    check_field("is_charging", got.is_charging, want.is_charging);
                end
                statuses_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Falling edge: request driver and result back-pressure. A request
    // stays up until taken; idle bursts only open after a handshake.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!req_if.valid || req_taken) begin
                if (req_taken && !quiet && $urandom_range(1, idle_odds) == 1)
                    req_gap = $urandom_range(1, IDLE_MAX);
                if (req_gap != 0) begin
                    req_gap--;
                    req_if.valid <= 1'b0;
                end else if (req_backlog_q.size() != 0) begin
                    nxt_req = req_backlog_q.pop_front();
                    req_if.op                <= nxt_req.op;
                    req_if.sample            <= nxt_req.sample;
                    req_if.charging_pin      <= nxt_req.pins[1];
                    req_if.charge_status_pin <= nxt_req.pins[0];
                    req_if.valid             <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            req_taken = 1'b0;

            // result side stalls in its own bursts, independent of the requests
            if (quiet) begin
                res_if.ready <= 1'b1;
            end else if (ready_gap != 0) begin
                ready_gap--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(1, idle_odds) == 1)
                    ready_gap = $urandom_range(1, IDLE_MAX);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d status reports outstanding",
                     cycle_count, status_due_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic void queue_req(input t_op op, input t_adc sample, input logic [1:0] pins);
        t_request r;
        r.op     = op;
        r.sample = sample;
        r.pins   = pins;
        req_backlog_q.push_back(r);
    endfunction

    // Mostly no charger; charging and full less often so the ladder still decides.
    function automatic logic [1:0] random_pins(input bit allow_full);
        int   pick;
        logic status_bit;
        pick       = $urandom_range(0, 7);
        status_bit = 1'($urandom_range(0, 1));
        if (pick < 5)
            return {1'b1, status_bit};
        if (pick == 7 && allow_full)
            return PINS_FULL;
        return PINS_CHARGING;
    endfunction

    // One window of samples scattered around target. The closing sample
    // carries close_pins, since those pins steer the grading. Side ops may be
    // slipped in between samples; keep_low_count leaves out the clear op.
    function automatic void queue_window(input int target, input int spread,
                                         input logic [1:0] close_pins, input bit side_ops,
                                         input bit keep_low_count);
        int  jit;
        int  s;
        t_op side;
        for (int k = 0; k < SAMPLES; k++) begin
            if (side_ops && $urandom_range(0, 23) == 0) begin
                side = keep_low_count ? t_op'($urandom_range(2, 3)) : t_op'($urandom_range(1, 3));
                queue_req(side, t_adc'($urandom_range(0, 4095)), random_pins(1'b1));
            end
            jit = $urandom_range(0, 2 * spread);
            s   = target + jit - spread;
            if (s < 0)
                s = 0;
            else if (s > 4095)
                s = 4095;
            queue_req(OP_SAMPLE, t_adc'(s),
                      (k == SAMPLES - 1) ? close_pins : random_pins(1'b1));
        end
    endfunction

    // Runs of windows aimed at the current thresholds, the critical band and
    // the one-volt mark, so that hysteresis and the low count get exercised.
    function automatic void queue_random_phase(input int total);
        int target;
        int spread;
        int runs;
        int pick;
        int off;
        while (req_backlog_q.size() < total) begin
            pick = $urandom_range(0, 9);
            off  = $urandom_range(0, 16);
            case (pick)
                0:       target = $urandom_range(0, 4095);
                1:       target = int'(ONE_VOLT_COUNT) + off - 8;
                2:       target = $urandom_range(0, int'(ONE_VOLT_COUNT) - 1);
                3, 4:    target = int'(thresh[REG_CRITICAL]) - off - 1;
                default: target = int'(thresh[t_cfg_idx'($urandom_range(0, NUM_REGS - 1))])
                                  + off - 8;
            endcase
            pick   = $urandom_range(0, 5);
            spread = (pick == 0) ? 0 : (pick == 5) ? 700 : 4;
            runs   = $urandom_range(1, 4);
            repeat (runs)
                queue_window(target, spread, random_pins(1'b1), 1'b1, 1'b0);
        end
    endfunction

    task automatic write_threshold(input t_cfg_idx idx, input t_adc value);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        cfg_if.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk) cfg_if.valid <= 1'b0;
    endtask

    task automatic load_thresholds(input t_adc vals [NUM_REGS]);
        for (int k = 0; k < NUM_REGS; k++)
            write_threshold(t_cfg_idx'(k), vals[k]);
    endtask

    // Wait for every request to be taken and every report to arrive, then let
    // trailing requests that yield no report leave the pipeline.
    task automatic settle();
        while (req_backlog_q.size() != 0 || req_if.valid || status_due_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin
        t_adc ladder [NUM_REGS];
        int   level;

        cfg_if.valid             = 1'b0;
        cfg_if.index             = REG_IGNORE;
        cfg_if.data              = '0;
        req_if.valid             = 1'b0;
        req_if.op                = OP_NONE;
        req_if.sample            = '0;
        req_if.charging_pin      = 1'b1;
        req_if.charge_status_pin = 1'b1;
        res_if.ready             = 1'b0;
        quiet                    = 1'b0;
        idle_odds                = 6;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed start on reset thresholds: undefined op, clear, full check
        // with and without full pins, then windows at both ends of the scale.
        queue_req(OP_NONE, 12'hFFF, PINS_CHARGING);
        queue_req(OP_CLEAR, 12'h000, PINS_NO_CHARGER);
        queue_req(OP_FULL, 12'h000, PINS_NO_CHARGER);
        queue_req(OP_FULL, 12'hFFF, PINS_FULL);
        // first window after reset is taken directly, then the full override
        queue_window(4095, 0, PINS_FULL, 1'b0, 1'b0);
        // zero average: ignored, but re-arms the direct first window
        queue_window(0, 0, PINS_CHARGING, 1'b0, 1'b0);
        // critical band straight after the sub-1V window
        queue_window(int'(REG_RESET[REG_CRITICAL]) - 20, 0, PINS_NO_CHARGER, 1'b0, 1'b0);
        queue_random_phase(320);
        settle();

        // Ascending random ladder, heavy idling on both sides.
        idle_odds = 3;
        level = $urandom_range(1800, 2600);
        for (int k = 0; k < NUM_REGS; k++) begin
            ladder[k] = t_adc'(level);
            level = level + $urandom_range(0, 250);
            if (level > 4095)
                level = 4095;
        end
        load_thresholds(ladder);
        queue_random_phase(200);
        settle();

        // All thresholds at zero: nothing ignored, nothing critical.
        idle_odds = 10;
        ladder = '{default: 12'd0};
        load_thresholds(ladder);
        queue_random_phase(120);
        settle();

        // All thresholds at full scale: nearly every average is ignored.
        ladder = '{default: 12'd4095};
        load_thresholds(ladder);
        queue_window(4095, 0, PINS_NO_CHARGER, 1'b0, 1'b0);
        queue_random_phase(120);
        settle();

        // Thresholds in no particular order; also a write to the unused index.
        idle_odds = 5;
        for (int k = 0; k < NUM_REGS; k++)
            ladder[k] = t_adc'($urandom_range(1500, 4095));
        load_thresholds(ladder);
        write_threshold(REG_SPARE, t_adc'($urandom_range(0, 4095)));
        queue_random_phase(180);
        settle();

        // Last part runs without idling. Every window grades critical and no
        // clear op or full closing pins come in, so the low count climbs far
        // past the shutdown mark.
        quiet = 1'b1;
        for (int k = 0; k < NUM_REGS; k++)
            ladder[k] = t_adc'($urandom_range(0, 4095));
        ladder[REG_IGNORE]   = 12'd0;
        ladder[REG_CRITICAL] = 12'd4095;
        load_thresholds(ladder);
        repeat (28)
            queue_window(2048, 2047, random_pins(1'b0), 1'b1, 1'b1);
        settle();

        // Back to the power-on thresholds, written explicitly.
        load_thresholds(REG_RESET);
        queue_random_phase(120);
        settle();

        $display("Checked %0d status reports from %0d requests (%0d windows closed, %0d threshold writes).",
                 statuses_checked, requests_taken, windows_closed, cfg_writes);
        $display("Threshold sets: power-on, ascending, all zero, all full scale, unordered, long critical run.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
